// ===== src/rapqt_pkg.sv =====
// ----------------------------------------------------------------------------
// rapqt_pkg
// Shared sizes, microcode types and the control store for the range-add,
// point-query segment tree.
// ----------------------------------------------------------------------------
package rapqt_pkg;

  localparam int unsigned LEAVES     = 1024;
  localparam int unsigned LOG_LEAVES = $clog2(LEAVES);
  localparam int unsigned NODES      = 2 * LEAVES;
  localparam int unsigned ADDR_W     = LOG_LEAVES + 1;
  localparam int unsigned IDX_W      = LOG_LEAVES + 2;
  localparam int unsigned DATA_W     = 64;
  localparam int unsigned UPC_W      = 4;

  // microprogram addresses
  localparam logic [UPC_W-1:0] A_TOP   = 4'd0;
  localparam logic [UPC_W-1:0] A_LO_RD = 4'd1;
  localparam logic [UPC_W-1:0] A_LO_WR = 4'd2;
  localparam logic [UPC_W-1:0] A_HI_RD = 4'd3;
  localparam logic [UPC_W-1:0] A_HI_WR = 4'd4;
  localparam logic [UPC_W-1:0] A_SHIFT = 4'd5;
  localparam logic [UPC_W-1:0] Q_RD    = 4'd6;
  localparam logic [UPC_W-1:0] Q_ACC   = 4'd7;
  localparam logic [UPC_W-1:0] Q_OUT   = 4'd8;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_RD_LO,
    OP_WR_LO,
    OP_RD_HI,
    OP_WR_HI,
    OP_SHIFT,
    OP_RD_IDX,
    OP_ACC_UP
  } op_e;

  typedef enum logic [2:0] {
    C_NEXT,
    C_JUMP,
    C_END,
    C_END_IF_EMPTY,
    C_JMP_LO_EVEN,
    C_JMP_HI_EVEN,
    C_JMP_NOT_ROOT,
    C_EMIT_END
  } cond_e;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [UPC_W-1:0] target;
  } uword_t;

  function automatic uword_t ucode_rom(input logic [UPC_W-1:0] upc);
    uword_t w;
    w = '{op: OP_NONE, cond: C_END, target: A_TOP};
    case (upc)
      A_TOP:   w = '{op: OP_NONE,   cond: C_END_IF_EMPTY, target: A_TOP};
      A_LO_RD: w = '{op: OP_RD_LO,  cond: C_JMP_LO_EVEN,  target: A_HI_RD};
      A_LO_WR: w = '{op: OP_WR_LO,  cond: C_NEXT,         target: A_TOP};
      A_HI_RD: w = '{op: OP_RD_HI,  cond: C_JMP_HI_EVEN,  target: A_SHIFT};
      A_HI_WR: w = '{op: OP_WR_HI,  cond: C_NEXT,         target: A_TOP};
      A_SHIFT: w = '{op: OP_SHIFT,  cond: C_JUMP,         target: A_TOP};
      Q_RD:    w = '{op: OP_RD_IDX, cond: C_NEXT,         target: A_TOP};
      Q_ACC:   w = '{op: OP_ACC_UP, cond: C_JMP_NOT_ROOT, target: Q_RD};
      Q_OUT:   w = '{op: OP_NONE,   cond: C_EMIT_END,     target: A_TOP};
      default: w = '{op: OP_NONE,   cond: C_END,          target: A_TOP};
    endcase
    return w;
  endfunction

endpackage

// ===== src/range_add_point_query_tree.sv =====
// ----------------------------------------------------------------------------
// range_add_point_query_tree
// Query: reads and accumulates each node on the path from the leaf up to the root,
// then strobes valid_o with the value; busy falls as the strobe rises.
// Add: per tree level, an empty-range check, a read of each boundary node, a write
// for each odd one, and a shift; each touched node is a read and a write step on the
// registered-read node store. Reset: busy stays high while every node is cleared.
// ----------------------------------------------------------------------------
module range_add_point_query_tree (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic                               cmd_i,
  input  logic        [9:0]                  range_start_i,
  input  logic        [10:0]                 range_end_i,
  input  logic signed [rapqt_pkg::DATA_W-1:0] delta_i,
  input  logic        [9:0]                  position_i,
  output logic                               valid_o,
  output logic signed [rapqt_pkg::DATA_W-1:0] point_value_o
);
  import rapqt_pkg::*;

  logic [DATA_W-1:0] mem [NODES];

  logic              clr_q, clr_d;
  logic [ADDR_W-1:0] clr_cnt_q, clr_cnt_d;
  logic              run_q, run_d;
  logic [UPC_W-1:0]  upc_q, upc_d;
  logic              valid_q, valid_d;

  logic [IDX_W-1:0]  lo_q, lo_d, hi_q, hi_d;
  logic [ADDR_W-1:0] idx_q, idx_d;
  logic [DATA_W-1:0] sum_q, sum_d, delta_q, delta_d;
  logic [DATA_W-1:0] rd_q;

  logic              accept;
  uword_t            uw;
  logic              we;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [DATA_W-1:0] wdata;
  logic [IDX_W-1:0]  lo_sat, hi_sat, hi_m1;

  assign busy          = clr_q | run_q;
  assign accept        = start & ~busy;
  assign uw            = ucode_rom(upc_q);
  assign valid_o       = valid_q;
  assign point_value_o = sum_q;
  assign hi_m1         = hi_q - IDX_W'(1);

  assign lo_sat = (32'(range_start_i) > 32'(LEAVES)) ? IDX_W'(LEAVES) : IDX_W'(range_start_i);
  assign hi_sat = (32'(range_end_i) > 32'(LEAVES)) ? IDX_W'(LEAVES) : IDX_W'(range_end_i);

  // sequencer
  always_comb begin
    clr_d     = clr_q;
    clr_cnt_d = clr_cnt_q;
    run_d     = run_q;
    upc_d     = upc_q;
    valid_d   = 1'b0;
    if (clr_q) begin
      clr_cnt_d = clr_cnt_q + ADDR_W'(1);
      if (clr_cnt_q == ADDR_W'(NODES - 1)) begin
        clr_d = 1'b0;
      end
    end else if (accept) begin
      run_d = 1'b1;
      upc_d = cmd_i ? Q_RD : A_TOP;
    end else if (run_q) begin
      upc_d = upc_q + UPC_W'(1);
      case (uw.cond)
        C_NEXT:         upc_d = upc_q + UPC_W'(1);
        C_JUMP:         upc_d = uw.target;
        C_END:          run_d = 1'b0;
        C_END_IF_EMPTY: begin
          if (lo_q >= hi_q) begin
            run_d = 1'b0;
          end
        end
        C_JMP_LO_EVEN:  begin
          if (!lo_q[0]) begin
            upc_d = uw.target;
          end
        end
        C_JMP_HI_EVEN:  begin
          if (!hi_q[0]) begin
            upc_d = uw.target;
          end
        end
        C_JMP_NOT_ROOT: begin
          if (idx_q > ADDR_W'(1)) begin
            upc_d = uw.target;
          end
        end
        C_EMIT_END:     begin
          run_d   = 1'b0;
          valid_d = 1'b1;
        end
        default:        run_d = 1'b0;
      endcase
    end
  end

  // datapath
  always_comb begin
    lo_d    = lo_q;
    hi_d    = hi_q;
    idx_d   = idx_q;
    sum_d   = sum_q;
    delta_d = delta_q;
    we      = 1'b0;
    waddr   = lo_q[ADDR_W-1:0];
    wdata   = rd_q + delta_q;
    raddr   = idx_q;
    if (clr_q) begin
      we    = 1'b1;
      waddr = clr_cnt_q;
      wdata = '0;
    end else if (accept) begin
      lo_d    = lo_sat + IDX_W'(LEAVES);
      hi_d    = hi_sat + IDX_W'(LEAVES);
      idx_d   = ADDR_W'(LEAVES) | ADDR_W'(32'(position_i) & 32'(LEAVES - 1));
      sum_d   = '0;
      delta_d = delta_i;
    end else if (run_q) begin
      case (uw.op)
        OP_NONE:   ;
        OP_RD_LO:  raddr = lo_q[ADDR_W-1:0];
        OP_WR_LO:  begin
          we    = 1'b1;
          waddr = lo_q[ADDR_W-1:0];
          lo_d  = lo_q + IDX_W'(1);
        end
        OP_RD_HI:  raddr = hi_m1[ADDR_W-1:0];
        OP_WR_HI:  begin
          we    = 1'b1;
          waddr = hi_m1[ADDR_W-1:0];
          hi_d  = hi_m1;
        end
        OP_SHIFT:  begin
          lo_d = lo_q >> 1;
          hi_d = hi_q >> 1;
        end
        OP_RD_IDX: raddr = idx_q;
        OP_ACC_UP: begin
          sum_d = sum_q + rd_q;
          idx_d = idx_q >> 1;
        end
        default:   ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= 1'b1;
      clr_cnt_q <= '0;
      run_q     <= 1'b0;
      upc_q     <= A_TOP;
      valid_q   <= 1'b0;
    end else begin
      clr_q     <= clr_d;
      clr_cnt_q <= clr_cnt_d;
      run_q     <= run_d;
      upc_q     <= upc_d;
      valid_q   <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    idx_q   <= idx_d;
    sum_q   <= sum_d;
    delta_q <= delta_d;
  end

  // node store
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

endmodule

// ===== verif/range_add_point_query_checker.sv =====
// ----------------------------------------------------------------------------
// range_add_point_query_checker
// Watches the command and result ports of the segment tree. Every accepted
// add is applied to a private copy of the node sums; every accepted query
// queues the value the tree should return, and each value strobe is compared
// in order against that queue. Mismatches and the number of values still
// owed are handed back to the testbench top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rapqt_tb_pkg;

  typedef enum logic {
    CMD_ADD   = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

endpackage

module range_add_point_query_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  input  logic                         busy,
  input  logic                         cmd_i,
  input  logic [9:0]                   range_start_i,
  input  logic [10:0]                  range_end_i,
  input  logic [rapqt_pkg::DATA_W-1:0] delta_i,
  input  logic [9:0]                   position_i,
  input  logic                         valid_i,
  input  logic [rapqt_pkg::DATA_W-1:0] point_value_i,
  output int unsigned                  mismatches_o,
  output int unsigned                  owed_o
);
  import rapqt_pkg::*;
  import rapqt_tb_pkg::*;

  logic [DATA_W-1:0] node_sum [NODES];
  logic [DATA_W-1:0] owed_values [$];
  logic [DATA_W-1:0] wanted;

  function automatic void add_to_range(input int unsigned first, input int unsigned stop,
                                       input logic [DATA_W-1:0] amount);
    int unsigned lo_idx;
    int unsigned hi_idx;
    lo_idx = (first > LEAVES) ? LEAVES : first;
    hi_idx = (stop > LEAVES) ? LEAVES : stop;
    if (lo_idx >= hi_idx) return;
    lo_idx += LEAVES;
    hi_idx += LEAVES;
    while (lo_idx < hi_idx) begin
      if ((lo_idx & 1) != 0) begin
        node_sum[ADDR_W'(lo_idx)] += amount;
        lo_idx++;
      end
      if ((hi_idx & 1) != 0) begin
        hi_idx--;
        node_sum[ADDR_W'(hi_idx)] += amount;
      end
      lo_idx >>= 1;
      hi_idx >>= 1;
    end
  endfunction

  function automatic logic [DATA_W-1:0] sum_at_position(input logic [9:0] pos);
    int unsigned idx;
    logic [DATA_W-1:0] acc;
    idx = (pos & (LEAVES - 1)) + LEAVES;
    acc = node_sum[ADDR_W'(idx)];
    while (idx > 1) begin
      idx >>= 1;
      acc += node_sum[ADDR_W'(idx)];
    end
    return acc;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NODES; k++) node_sum[ADDR_W'(k)] = '0;
      owed_values.delete();
      mismatches_o <= 0;
      owed_o       <= 0;
    end else begin
      if (valid_i) begin
        if (owed_values.size() == 0) begin
          $display("%0t: point_value beat with none owed: expected none, got %h",
                   $time, point_value_i);
          mismatches_o <= mismatches_o + 1;
        end else begin
          wanted = owed_values.pop_front();
          if (point_value_i !== wanted) begin
            $display("%0t: point_value mismatch: expected %h, got %h",
                     $time, wanted, point_value_i);
            mismatches_o <= mismatches_o + 1;
          end
        end
      end
      if (start && !busy) begin
        if (cmd_i == CMD_QUERY) owed_values.push_back(sum_at_position(position_i));
        else add_to_range(32'(range_start_i), 32'(range_end_i), delta_i);
      end
      owed_o <= owed_values.size();
    end
  end

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives add and query commands into the range-add, point-query segment tree
// in random bursts: a directed opening over field extremes, empty, reversed
// and oversized ranges, then a random mix of mostly well-formed adds and
// queries. Checking is done by the checker instance beside the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import rapqt_pkg::*;
  import rapqt_tb_pkg::*;

  localparam int unsigned ITEMS = 550;

  logic              clk_i;
  logic              rst_ni;
  logic              start;
  logic              busy;
  logic              cmd_i;
  logic [9:0]        range_start_i;
  logic [10:0]       range_end_i;
  logic [DATA_W-1:0] delta_i;
  logic [9:0]        position_i;
  logic              valid_o;
  logic [DATA_W-1:0] point_value_o;
  int unsigned       mismatches;
  int unsigned       owed;
  int unsigned       burst_left;

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  range_add_point_query_tree i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .cmd_i         (cmd_i),
    .range_start_i (range_start_i),
    .range_end_i   (range_end_i),
    .delta_i       (delta_i),
    .position_i    (position_i),
    .valid_o       (valid_o),
    .point_value_o (point_value_o)
  );

  range_add_point_query_checker i_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .cmd_i         (cmd_i),
    .range_start_i (range_start_i),
    .range_end_i   (range_end_i),
    .delta_i       (delta_i),
    .position_i    (position_i),
    .valid_i       (valid_o),
    .point_value_i (point_value_o),
    .mismatches_o  (mismatches),
    .owed_o        (owed)
  );

  // one beat, then a gap at the end of each burst
  task automatic issue(input cmd_e op, input logic [9:0] first, input logic [10:0] stop,
                       input logic [DATA_W-1:0] amount, input logic [9:0] pos);
    int unsigned gap;
    start         <= 1'b1;
    cmd_i         <= op;
    range_start_i <= first;
    range_end_i   <= stop;
    delta_i       <= amount;
    position_i    <= pos;
    do @(posedge clk_i); while (busy);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 8);
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end else begin
      burst_left--;
    end
  endtask

  task automatic settle();
    start <= 1'b0;
    @(posedge clk_i);
    while (owed != 0) @(posedge clk_i);
  endtask

  initial begin
    logic [9:0]        lo;
    logic [10:0]       hi;
    logic [DATA_W-1:0] amount;
    int unsigned       pick;
    rst_ni        <= 1'b0;
    start         <= 1'b0;
    cmd_i         <= CMD_ADD;
    range_start_i <= '0;
    range_end_i   <= '0;
    delta_i       <= '0;
    position_i    <= '0;
    burst_left    = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    issue(CMD_QUERY, 10'd0, 11'd0, 64'd0, 10'd0);
    issue(CMD_ADD, 10'd0, 11'd1024, 64'h7FFF_FFFF_FFFF_FFFF, 10'd0);
    issue(CMD_QUERY, 10'd0, 11'd0, 64'd0, 10'd0);
    issue(CMD_QUERY, 10'd0, 11'd0, 64'd0, 10'd1023);
    issue(CMD_ADD, 10'd0, 11'd1024, 64'h8000_0000_0000_0000, 10'd0);
    issue(CMD_QUERY, 10'd0, 11'd0, 64'd0, 10'd512);
    issue(CMD_ADD, 10'd1023, 11'd1024, '1, 10'd0);
    issue(CMD_ADD, 10'd0, 11'd1, 64'd1, 10'd0);
    issue(CMD_ADD, 10'd5, 11'd5, 64'd99, 10'd5);
    issue(CMD_ADD, 10'd700, 11'd300, 64'd12345, 10'd700);
    issue(CMD_ADD, 10'd1000, 11'd2047, 64'h0123_4567_89AB_CDEF, 10'd0);
    issue(CMD_ADD, 10'd1023, 11'd1536, 64'hFEDC_BA98_7654_3210, 10'd0);
    issue(CMD_ADD, 10'd1023, 11'd1023, '1, 10'd1023);
    issue(CMD_ADD, 10'd3, 11'd17, 64'h5A5A_A5A5_0F0F_F0F0, 10'd1023);
    issue(CMD_QUERY, 10'd1023, 11'd2047, '1, 10'd1023);
    issue(CMD_QUERY, 10'd1023, 11'd2047, '1, 10'd0);
    issue(CMD_QUERY, 10'd0, 11'd0, 64'd0, 10'd16);
    issue(CMD_QUERY, 10'd0, 11'd0, 64'd0, 10'd17);
    issue(CMD_QUERY, 10'd0, 11'd0, 64'd0, 10'd1000);
    issue(CMD_QUERY, 10'd0, 11'd0, 64'd0, 10'd5);
    issue(CMD_ADD, 10'd1, 11'd1023, 64'h5555_5555_5555_5555, 10'd0);
    issue(CMD_QUERY, 10'd0, 11'd0, 64'd0, 10'd511);
    issue(CMD_QUERY, 10'd0, 11'd0, 64'd0, 10'd1022);
    settle();

    for (int n = 0; n < ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      lo   = 10'($urandom_range(0, 1023));
      case ($urandom_range(0, 3))
        0: amount = {$urandom, $urandom};
        1: amount = $urandom_range(0, 1) ? 64'h7FFF_FFFF_FFFF_FFFF : 64'h8000_0000_0000_0000;
        default: begin
          amount = {54'd0, 10'($urandom_range(0, 1023))};
          if ($urandom_range(0, 1) == 1) amount = -amount;
        end
      endcase
      if (pick < 45) begin
        issue(CMD_QUERY, lo, 11'($urandom_range(0, 2047)), amount,
              10'($urandom_range(0, 1023)));
      end else begin
        if (pick < 85) hi = 11'($urandom_range(32'(lo) + 1, 1024));
        else if (pick < 92) hi = 11'($urandom_range(0, 32'(lo)));
        else hi = 11'($urandom_range(1025, 2047));
        issue(CMD_ADD, lo, hi, amount, 10'($urandom_range(0, 1023)));
      end
      if (n == ITEMS / 3 || n == 2 * ITEMS / 3) settle();
    end

    settle();
    repeat (80) @(posedge clk_i);
    if (mismatches == 0 && owed == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== range_add_point_query_tree.f =====
src/rapqt_pkg.sv
src/range_add_point_query_tree.sv
verif/range_add_point_query_checker.sv
verif/tb_top.sv
